/* src/kmm_pkg.sv */
// Shared types, constants and codes of the keypoint motion matcher.
`default_nettype none
package kmm_pkg;

	localparam int KMM_MAX_POINTS = 64;
	localparam int KMM_IDX_W      = $clog2(KMM_MAX_POINTS);
	localparam int KMM_CNT_W      = $clog2(KMM_MAX_POINTS + 1);

	localparam logic [15:0] KMM_MIN_DIST_RST = 16'd32;
	localparam logic [15:0] KMM_MAX_DIST_RST = 16'd160;
	localparam logic signed [16:0] KMM_MIN_SC_RST = 17'sd0;
	localparam logic signed [16:0] KMM_MAX_SC_RST = 17'sd160;

	typedef enum logic [1:0] {
		FUNC_REF     = 2'd0,
		FUNC_CUR     = 2'd1,
		FUNC_COMPUTE = 2'd2,
		FUNC_CLEAR   = 2'd3
	} kmm_func_t;

	typedef enum logic [1:0] {
		REG_MIN_DIST = 2'd0,
		REG_MAX_DIST = 2'd1,
		REG_MIN_SC   = 2'd2,
		REG_MAX_SC   = 2'd3
	} kmm_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DMIN,
		ST_DMAX,
		ST_DLOAD,
		ST_REF_RD,
		ST_CUR_RD,
		ST_SQX,
		ST_SQY,
		ST_CMP,
		ST_CLAIM_RD,
		ST_DECIDE,
		ST_WRITE,
		ST_OUT_RD,
		ST_OUT_LOAD,
		ST_OUT_WAIT
	} kmm_state_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] s;
	} kmm_point_t;

	typedef struct packed {
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic signed [16:0] ds;
	} kmm_motion_t;

	typedef struct packed {
		logic [KMM_IDX_W-1:0] owner;
		logic [31:0]          dist_sq;
	} kmm_claim_t;

endpackage
`default_nettype wire

/* src/kmm_ifs.sv */
// Point input and motion result channel interfaces.
`default_nettype none
interface kmm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [15:0] blob_size;

	modport source(output valid, func, pos_x, pos_y, blob_size, input ready);
	modport sink(input valid, func, pos_x, pos_y, blob_size, output ready);
endinterface

interface kmm_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         ref_index;
	logic               moved;
	logic signed [16:0] shift_x;
	logic signed [16:0] shift_y;
	logic signed [16:0] size_change;
	logic               overflow;
	logic               last;

	modport source(output valid, ref_index, moved, shift_x, shift_y, size_change,
		overflow, last, input ready);
	modport sink(input valid, ref_index, moved, shift_x, shift_y, size_change,
		overflow, last, output ready);
endinterface
`default_nettype wire

/* src/keypoint_motion_matcher_top.sv */
// Top level of the keypoint motion matcher: sequencer, point stores and claims.
//   points  : input channel, valid/ready. func selects the operation:
//             append reference point, append current point, compute, or
//             clear the reference set. Appends beyond the set capacity
//             are dropped and flagged.
//   motions : output channel, valid/ready. A compute transaction yields one
//             result per reference point, in index order, last set on the
//             final one; no results when the reference set is empty.
//   cfg_*   : register write port (distance and size change windows). The user
//             must write it only while the block is idle; it is not enforced.
// Matching: each candidate pair goes through a read of the current point store,
//   two passes through the one shared squarer (x then y), then the
//   running-minimum compare.
// points.ready is low for the whole compute; a stalled receiver holds the
//   current result in the output register until it is taken.
// Reset clears both counts, the overflow flag and the output valid and loads
//   the register defaults. After the last result the current set and overflow
//   flag are cleared; the reference set is kept.
`default_nettype none
module keypoint_motion_matcher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	kmm_in_if.sink           points,
	kmm_out_if.source        motions,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data
);
	localparam int IW = kmm_pkg::KMM_IDX_W;
	localparam int CW = kmm_pkg::KMM_CNT_W;
	localparam int MP = kmm_pkg::KMM_MAX_POINTS;

	// configuration registers
	logic [15:0]        min_dist_q;
	logic [15:0]        max_dist_q;
	logic signed [16:0] min_sc_q;
	logic signed [16:0] max_sc_q;

	// control state
	kmm_pkg::kmm_state_t state_q, state_d;
	logic [CW-1:0] ref_count_q;
	logic [CW-1:0] cur_count_q;
	logic          ovf_q;
	logic [IW-1:0] p_q;
	logic [CW-1:0] c_q;
	logic          found_q;
	logic [MP-1:0] claim_valid_q;
	logic          out_valid_q;

	// datapath registers
	logic [31:0]          dmin2_q;
	logic [31:0]          dmax2_q;
	logic [31:0]          best_q;
	logic [31:0]          acc_q;
	logic [IW-1:0]        bi_q;
	kmm_pkg::kmm_motion_t m_q;

	// output register
	logic [5:0]         out_index_q;
	logic               out_moved_q;
	logic signed [16:0] out_dx_q;
	logic signed [16:0] out_dy_q;
	logic signed [16:0] out_ds_q;
	logic               out_ovf_q;
	logic               out_last_q;

	// memories and their registered read data
	kmm_pkg::kmm_point_t  ref_mem [MP];
	kmm_pkg::kmm_point_t  cur_mem [MP];
	kmm_pkg::kmm_motion_t mot_mem [MP];
	kmm_pkg::kmm_claim_t  clm_mem [MP];
	kmm_pkg::kmm_point_t  ref_rd_q;
	kmm_pkg::kmm_point_t  cur_rd_q;
	kmm_pkg::kmm_motion_t mot_rd_q;
	kmm_pkg::kmm_claim_t  clm_rd_q;

	// sequencer outputs
	logic          in_rdy;
	logic          ref_re;
	logic          cur_re;
	logic [IW-1:0] cur_raddr;
	logic          mot_re;
	logic          clm_re;
	logic [15:0]   sq_a;
	logic [15:0]   sq_b;

	logic [31:0]   sq_s1;
	logic          in_acc;
	logic          out_acc;
	kmm_pkg::kmm_func_t func;
	logic          ref_room;
	logic          cur_room;
	logic          more_cur;
	logic          last_p;
	logic [32:0]   d2;
	logic          closer;
	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic signed [16:0] ds;
	logic          keep;

	kmm_sq_unit u_sq (
		.clk   (clk),
		.a     (sq_a),
		.b     (sq_b),
		.sq_s1 (sq_s1)
	);

	assign func     = kmm_pkg::kmm_func_t'(points.func);
	assign in_acc   = points.valid & in_rdy;
	assign out_acc  = out_valid_q & motions.ready;
	assign ref_room = ref_count_q < CW'(MP);
	assign cur_room = cur_count_q < CW'(MP);
	assign more_cur = c_q < cur_count_q;
	assign last_p   = (CW'(p_q) + CW'(1)) == ref_count_q;

	assign d2     = {1'b0, acc_q} + {1'b0, sq_s1};
	assign closer = d2 < {1'b0, best_q};

	assign dx = $signed({1'b0, cur_rd_q.x} - {1'b0, ref_rd_q.x});
	assign dy = $signed({1'b0, cur_rd_q.y} - {1'b0, ref_rd_q.y});
	assign ds = $signed({1'b0, cur_rd_q.s} - {1'b0, ref_rd_q.s});
	// match kept: far enough, size change in window, claim free or farther
	assign keep = found_q && (best_q >= dmin2_q) && (ds >= min_sc_q) && (ds < max_sc_q)
		&& (!claim_valid_q[bi_q] || (clm_rd_q.dist_sq > best_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kmm_pkg::ST_IDLE: begin
				if (in_acc && func == kmm_pkg::FUNC_COMPUTE && ref_count_q != '0)
					state_d = kmm_pkg::ST_DMIN;
			end
			kmm_pkg::ST_DMIN:     state_d = kmm_pkg::ST_DMAX;
			kmm_pkg::ST_DMAX:     state_d = kmm_pkg::ST_DLOAD;
			kmm_pkg::ST_DLOAD:    state_d = kmm_pkg::ST_REF_RD;
			kmm_pkg::ST_REF_RD:   state_d = kmm_pkg::ST_CUR_RD;
			kmm_pkg::ST_CUR_RD: begin
				state_d = more_cur ? kmm_pkg::ST_SQX : kmm_pkg::ST_CLAIM_RD;
			end
			kmm_pkg::ST_SQX:      state_d = kmm_pkg::ST_SQY;
			kmm_pkg::ST_SQY:      state_d = kmm_pkg::ST_CMP;
			kmm_pkg::ST_CMP:      state_d = kmm_pkg::ST_CUR_RD;
			kmm_pkg::ST_CLAIM_RD: state_d = kmm_pkg::ST_DECIDE;
			kmm_pkg::ST_DECIDE:   state_d = kmm_pkg::ST_WRITE;
			kmm_pkg::ST_WRITE: begin
				state_d = last_p ? kmm_pkg::ST_OUT_RD : kmm_pkg::ST_REF_RD;
			end
			kmm_pkg::ST_OUT_RD:   state_d = kmm_pkg::ST_OUT_LOAD;
			kmm_pkg::ST_OUT_LOAD: state_d = kmm_pkg::ST_OUT_WAIT;
			kmm_pkg::ST_OUT_WAIT: begin
				if (out_acc)
					state_d = out_last_q ? kmm_pkg::ST_IDLE : kmm_pkg::ST_OUT_RD;
			end
			default:              state_d = kmm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_rdy    = 1'b0;
		ref_re    = 1'b0;
		cur_re    = 1'b0;
		cur_raddr = c_q[IW-1:0];
		mot_re    = 1'b0;
		clm_re    = 1'b0;
		sq_a      = cur_rd_q.x;
		sq_b      = ref_rd_q.x;
		case (state_q)
			kmm_pkg::ST_IDLE:   in_rdy = 1'b1;
			kmm_pkg::ST_DMIN: begin
				sq_a = min_dist_q;
				sq_b = '0;
			end
			kmm_pkg::ST_DMAX: begin
				sq_a = max_dist_q;
				sq_b = '0;
			end
			kmm_pkg::ST_REF_RD: ref_re = 1'b1;
			kmm_pkg::ST_CUR_RD: cur_re = more_cur;
			kmm_pkg::ST_SQY: begin
				sq_a = cur_rd_q.y;
				sq_b = ref_rd_q.y;
			end
			kmm_pkg::ST_CLAIM_RD: begin
				cur_re    = 1'b1;
				cur_raddr = bi_q;
				clm_re    = 1'b1;
			end
			kmm_pkg::ST_OUT_RD: mot_re = 1'b1;
			default: ;
		endcase
	end

	assign points.ready = in_rdy;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= kmm_pkg::ST_IDLE;
			ref_count_q   <= '0;
			cur_count_q   <= '0;
			ovf_q         <= 1'b0;
			p_q           <= '0;
			c_q           <= '0;
			found_q       <= 1'b0;
			claim_valid_q <= '0;
			out_valid_q   <= 1'b0;
			min_dist_q    <= kmm_pkg::KMM_MIN_DIST_RST;
			max_dist_q    <= kmm_pkg::KMM_MAX_DIST_RST;
			min_sc_q      <= kmm_pkg::KMM_MIN_SC_RST;
			max_sc_q      <= kmm_pkg::KMM_MAX_SC_RST;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (kmm_pkg::kmm_reg_t'(cfg_index))
					kmm_pkg::REG_MIN_DIST: min_dist_q <= cfg_data[15:0];
					kmm_pkg::REG_MAX_DIST: max_dist_q <= cfg_data[15:0];
					kmm_pkg::REG_MIN_SC:   min_sc_q   <= $signed(cfg_data);
					kmm_pkg::REG_MAX_SC:   max_sc_q   <= $signed(cfg_data);
					default: ;
				endcase
			end

			case (state_q)
				kmm_pkg::ST_IDLE: begin
					if (in_acc) begin
						case (func)
							kmm_pkg::FUNC_REF: begin
								if (ref_room) ref_count_q <= ref_count_q + CW'(1);
								else          ovf_q       <= 1'b1;
							end
							kmm_pkg::FUNC_CUR: begin
								if (cur_room) cur_count_q <= cur_count_q + CW'(1);
								else          ovf_q       <= 1'b1;
							end
							kmm_pkg::FUNC_COMPUTE: begin
								p_q <= '0;
								// empty reference set: no results, just start a new frame
								if (ref_count_q == '0) begin
									cur_count_q <= '0;
									ovf_q       <= 1'b0;
								end
							end
							kmm_pkg::FUNC_CLEAR: ref_count_q <= '0;
							default: ;
						endcase
					end
				end
				kmm_pkg::ST_DMAX: claim_valid_q <= '0;
				kmm_pkg::ST_REF_RD: begin
					c_q     <= '0;
					found_q <= 1'b0;
				end
				kmm_pkg::ST_CMP: begin
					c_q <= c_q + CW'(1);
					if (closer) found_q <= 1'b1;
				end
				kmm_pkg::ST_DECIDE: begin
					if (keep) claim_valid_q[bi_q] <= 1'b1;
				end
				kmm_pkg::ST_WRITE: begin
					p_q <= last_p ? '0 : p_q + IW'(1);
				end
				kmm_pkg::ST_OUT_LOAD: out_valid_q <= 1'b1;
				kmm_pkg::ST_OUT_WAIT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						p_q         <= p_q + IW'(1);
						if (out_last_q) begin
							cur_count_q <= '0;
							ovf_q       <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			kmm_pkg::ST_DMAX:   dmin2_q <= sq_s1;
			kmm_pkg::ST_DLOAD:  dmax2_q <= sq_s1;
			kmm_pkg::ST_REF_RD: begin
				best_q <= dmax2_q;
				bi_q   <= '0;
			end
			kmm_pkg::ST_SQY:    acc_q <= sq_s1;
			kmm_pkg::ST_CMP: begin
				if (closer) begin
					best_q <= d2[31:0];
					bi_q   <= c_q[IW-1:0];
				end
			end
			kmm_pkg::ST_DECIDE: begin
				if (keep) begin
					m_q.dx <= dx;
					m_q.dy <= dy;
					m_q.ds <= ds;
				end else begin
					m_q <= '0;
				end
			end
			kmm_pkg::ST_OUT_LOAD: begin
				out_index_q <= 6'(p_q);
				out_moved_q <= (mot_rd_q.dx != '0) || (mot_rd_q.dy != '0);
				out_dx_q    <= mot_rd_q.dx;
				out_dy_q    <= mot_rd_q.dy;
				out_ds_q    <= mot_rd_q.ds;
				out_ovf_q   <= ovf_q;
				out_last_q  <= last_p;
			end
			default: ;
		endcase
	end

	// reference point store
	always_ff @(posedge clk) begin
		if (in_acc && func == kmm_pkg::FUNC_REF && ref_room)
			ref_mem[ref_count_q[IW-1:0]] <= {points.pos_x, points.pos_y, points.blob_size};
		if (ref_re)
			ref_rd_q <= ref_mem[p_q];
	end

	// current point store
	always_ff @(posedge clk) begin
		if (in_acc && func == kmm_pkg::FUNC_CUR && cur_room)
			cur_mem[cur_count_q[IW-1:0]] <= {points.pos_x, points.pos_y, points.blob_size};
		if (cur_re)
			cur_rd_q <= cur_mem[cur_raddr];
	end

	// motion store: a takeover zeroes the earlier claimant, then each point is written
	always_ff @(posedge clk) begin
		if (state_q == kmm_pkg::ST_DECIDE && keep && claim_valid_q[bi_q])
			mot_mem[clm_rd_q.owner] <= '0;
		else if (state_q == kmm_pkg::ST_WRITE)
			mot_mem[p_q] <= m_q;
		if (mot_re)
			mot_rd_q <= mot_mem[p_q];
	end

	// claim store: owner and distance of each claimed current point
	always_ff @(posedge clk) begin
		if (state_q == kmm_pkg::ST_DECIDE && keep) begin
			clm_mem[bi_q].owner   <= p_q;
			clm_mem[bi_q].dist_sq <= best_q;
		end
		if (clm_re)
			clm_rd_q <= clm_mem[bi_q];
	end

	assign motions.valid       = out_valid_q;
	assign motions.ref_index   = out_index_q;
	assign motions.moved       = out_moved_q;
	assign motions.shift_x     = out_dx_q;
	assign motions.shift_y     = out_dy_q;
	assign motions.size_change = out_ds_q;
	assign motions.overflow    = out_ovf_q;
	assign motions.last        = out_last_q;

	// the running minimum never rises above the rejection bound
	a_best_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kmm_pkg::ST_CMP |-> best_q <= dmax2_q)
		else $error("best distance above max bound");

	// no new transaction is taken while a result is pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !points.ready)
		else $error("input ready while result pending");

	// a result is offered only in the output wait state
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == kmm_pkg::ST_OUT_WAIT)
		else $error("result valid outside output state");

	// the last result returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_last_q |=> state_q == kmm_pkg::ST_IDLE)
		else $error("block not idle after last result");

	// counts never exceed the set capacity
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		ref_count_q <= CW'(MP) && cur_count_q <= CW'(MP))
		else $error("point count above capacity");
endmodule
`default_nettype wire

/* src/kmm_sq_unit.sv */
// Shared squarer: registered square of the difference of two unsigned words.
`default_nettype none
module kmm_sq_unit (
	input  wire logic        clk,
	input  wire logic [15:0] a,
	input  wire logic [15:0] b,
	output logic      [31:0] sq_s1
);
	logic [16:0] diff;
	logic [15:0] mag;

	assign diff = {1'b0, a} - {1'b0, b};
	// magnitude never exceeds 16 bits
	assign mag  = diff[16] ? 16'(17'd0 - diff) : diff[15:0];

	always_ff @(posedge clk) begin
		sq_s1 <= mag * mag;
	end
endmodule
`default_nettype wire
